// ----- rtl/core/wtse_pkg.sv -----
// wtse_pkg: widths, register codes, shared structs and the sequencer state type
// for the weighted target selector; no dependencies
package wtse_pkg;

    localparam int COORD_BITS = 16;
    localparam int ID_BITS    = 16;

    localparam int OFF_W    = COORD_BITS + 1;
    localparam int ACC_W    = COORD_BITS + 9;
    localparam int ROOT_W   = COORD_BITS + 1;
    localparam int SQ_W     = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 3;
    localparam int RCNT_W   = $clog2(ROOT_W + 1);
    localparam int DEN_W    = (ROOT_W + 1 > 16) ? ROOT_W + 1 : 16;
    localparam int NUM_W    = 27;
    localparam int DCNT_W   = $clog2(NUM_W + 1);
    localparam int SCORE_W  = 22;
    localparam int WGT_W    = 16;
    localparam int ALPHA_W  = 17;
    localparam int CONF_W   = 17;
    localparam int ETA_W    = 15;
    localparam int PROX_W   = 17;
    localparam int SACC_W   = 35;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = (COORD_BITS > ID_BITS)
                            ? ((COORD_BITS > ALPHA_W) ? COORD_BITS : ALPHA_W)
                            : ((ID_BITS > ALPHA_W) ? ID_BITS : ALPHA_W);

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
    localparam logic [WGT_W-1:0]   WGT_ONE   = WGT_W'(4096);
    localparam logic [NUM_W-1:0]   NUM_PROX  = NUM_W'(1) << 20;
    localparam logic [NUM_W-1:0]   NUM_STAB  = NUM_W'(1) << 26;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_PROX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_CONF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W_STAB   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_ID  = 3'd6;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [WGT_W-1:0]      w_prox;
        logic [WGT_W-1:0]      w_conf;
        logic [WGT_W-1:0]      w_stab;
        logic [ALPHA_W-1:0]    alpha;
        logic [ID_BITS-1:0]    lock_id;
        logic                  lock_wr;
    } cfg_t;

    typedef struct packed {
        logic                  present;
        logic                  scored;
        logic                  lock_match;
        logic                  last;
        logic [ID_BITS-1:0]    id;
        logic [COORD_BITS-1:0] u;
        logic [COORD_BITS-1:0] v;
        logic [CONF_W-1:0]     conf;
        logic [ETA_W-1:0]      eta;
    } item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQU,
        S_SQV,
        S_SQRT,
        S_DIVP_GO,
        S_DIVP_W,
        S_DIVS_GO,
        S_DIVS_W,
        S_MULP,
        S_MULC,
        S_MULS,
        S_RANK,
        S_FRAME,
        S_EMA_A,
        S_EMA_B,
        S_EMA_C,
        S_EMIT
    } back_state_t;

endpackage

// ----- rtl/core/wtse_front.sv -----
// wtse_front: takes input transfers, classifies each track and queues it
// for the back end; depends on wtse_pkg
module wtse_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           track_present,
    input  logic [wtse_pkg::ID_BITS-1:0]   track_id,
    input  logic                           confirmed,
    input  logic                           parent_label,
    input  logic [wtse_pkg::COORD_BITS-1:0] pos_u,
    input  logic [wtse_pkg::COORD_BITS-1:0] pos_v,
    input  logic signed [15:0]             confidence,
    input  logic signed [15:0]             eta_mean,
    input  logic                           last_in_frame,
    input  logic [wtse_pkg::ID_BITS-1:0]   lock_id,
    input  logic                           q_pop,
    output logic                           q_empty,
    output wtse_pkg::item_t                q_head
);

    wtse_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    wtse_pkg::item_t cls;
    logic            wr_en;

    // classification of the incoming track
    always_comb
    begin
        cls.present    = track_present;
        cls.scored     = track_present & confirmed & parent_label;
        cls.lock_match = (track_id == lock_id);
        cls.last       = last_in_frame;
        cls.id         = track_id;
        cls.u          = pos_u;
        cls.v          = pos_v;
        cls.conf       = confidence[15] ? '0 : {1'b0, confidence[14:0], 1'b0};
        cls.eta        = eta_mean[15] ? '0 : eta_mean[14:0];
    end

    // two-entry queue pointers
    assign full    = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign wr_en   = push & ~full;
    assign q_head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(wr_en) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- rtl/core/wtse_div.sv -----
// wtse_div: restoring unsigned divider, one quotient bit per cycle
// depends on wtse_pkg
module wtse_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wtse_pkg::NUM_W-1:0]  num,
    input  logic [wtse_pkg::DEN_W-1:0]  den,
    output logic                        busy,
    output logic [wtse_pkg::NUM_W-1:0]  quo
);

    logic [wtse_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [wtse_pkg::NUM_W-1:0]  q_reg, q_next;
    logic [wtse_pkg::DEN_W:0]    rem_reg, rem_next;
    logic [wtse_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [wtse_pkg::DEN_W:0]    shifted;

    assign busy = (cnt_reg != '0);
    assign quo  = q_reg;

    // one shift and subtract step
    always_comb
    begin
        shifted  = {rem_reg[wtse_pkg::DEN_W-1:0], q_reg[wtse_pkg::NUM_W-1]};
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = wtse_pkg::DCNT_W'(wtse_pkg::NUM_W);
            q_next   = num;
            rem_next = '0;
            den_next = den;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[wtse_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[wtse_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// ----- rtl/core/wtse_back.sv -----
// wtse_back: scoring sequencer, frame ranking, EMA and result register
// depends on wtse_pkg and wtse_div
module wtse_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wtse_pkg::cfg_t                     cfg,
    input  logic                               q_empty,
    input  wtse_pkg::item_t                    q_head,
    output logic                               q_pop,
    input  logic                               pop,
    output logic                               empty,
    output logic                               target_valid,
    output logic [wtse_pkg::ID_BITS-1:0]       target_id,
    output logic signed [wtse_pkg::OFF_W-1:0]  raw_dx,
    output logic signed [wtse_pkg::OFF_W-1:0]  raw_dy,
    output logic signed [wtse_pkg::OFF_W-1:0]  smooth_dx,
    output logic signed [wtse_pkg::OFF_W-1:0]  smooth_dy,
    output logic [wtse_pkg::SCORE_W-1:0]       score
);

    localparam int CB   = wtse_pkg::COORD_BITS;
    localparam int OW   = wtse_pkg::OFF_W;
    localparam int AW   = wtse_pkg::ACC_W;
    localparam int P1_W = AW + wtse_pkg::ALPHA_W + 1;
    localparam int P2_W = OW + wtse_pkg::ALPHA_W + 1;
    localparam int SUM_W = P1_W + 1;

    wtse_pkg::back_state_t state_reg, state_next;
    wtse_pkg::item_t       item_reg;

    // control
    logic div_start, div_busy, out_load;
    logic [wtse_pkg::NUM_W-1:0] div_num, div_quo;
    logic [wtse_pkg::DEN_W-1:0] div_den;

    // datapath registers
    logic [wtse_pkg::SQ_W-1:0]    sq_reg;
    logic [wtse_pkg::REM_W-1:0]   rem_reg;
    logic [wtse_pkg::ROOT_W-1:0]  root_reg;
    logic [wtse_pkg::RCNT_W-1:0]  rcnt_reg;
    logic [wtse_pkg::PROX_W-1:0]  prox_reg, stab_reg;
    logic [wtse_pkg::SACC_W-1:0]  sacc_reg;

    logic                         best_found_reg;
    logic [wtse_pkg::SCORE_W-1:0] best_score_reg;
    logic [wtse_pkg::ID_BITS-1:0] best_id_reg;
    logic [CB-1:0]                best_u_reg, best_v_reg;
    logic                         lock_seen_reg, lock_void_reg;
    logic [CB-1:0]                lock_u_reg, lock_v_reg;
    logic                         have_smooth_reg;
    logic [wtse_pkg::ID_BITS-1:0] prev_id_reg;
    logic signed [AW-1:0]         acc_x_reg, acc_y_reg;
    logic signed [P1_W-1:0]       p1_reg;
    logic signed [P2_W-1:0]       p2_reg;
    logic                         lane_reg;

    logic                         res_valid_reg;
    logic [wtse_pkg::ID_BITS-1:0] res_id_reg;
    logic signed [OW-1:0]         res_dx_reg, res_dy_reg;
    logic [wtse_pkg::SCORE_W-1:0] res_score_reg;
    logic                         out_valid_reg;

    // combinational datapath
    logic signed [OW-1:0]         d_sel;
    logic [OW-1:0]                d_mag;
    logic [2*CB-1:0]              sq_prod;
    logic [wtse_pkg::REM_W-1:0]   rem_sh, trial;
    logic [wtse_pkg::WGT_W-1:0]   mul_a;
    logic [wtse_pkg::PROX_W-1:0]  mul_b;
    logic [wtse_pkg::SACC_W-1:0]  mul_p;
    logic [wtse_pkg::SACC_W-13:0] s_full;
    logic [wtse_pkg::SCORE_W-1:0] s_sat;
    logic                         lock_active;
    logic                         pick_lock, pick_valid;
    logic [wtse_pkg::ID_BITS-1:0] pick_id;
    logic [CB-1:0]                pick_u, pick_v;
    logic signed [OW-1:0]         pick_dx, pick_dy;
    logic                         restart;
    logic [wtse_pkg::ALPHA_W-1:0] oma;
    logic signed [AW-1:0]         acc_sel;
    logic signed [OW-1:0]         raw_sel;
    logic signed [SUM_W-1:0]      ema_sum;
    logic signed [AW-1:0]         ema_new;
    logic signed [AW:0]           sm_x, sm_y;

    wtse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // offset magnitude and square, u in state S_SQU and v in state S_SQV
    always_comb
    begin
        if (state_reg == wtse_pkg::S_SQU)
        begin
            d_sel = $signed({1'b0, item_reg.u}) - $signed({1'b0, cfg.center_x});
        end
        else
        begin
            d_sel = $signed({1'b0, item_reg.v}) - $signed({1'b0, cfg.center_y});
        end
        d_mag   = d_sel[OW-1] ? OW'(-d_sel) : OW'(d_sel);
        sq_prod = d_mag[CB-1:0] * d_mag[CB-1:0];
    end

    // square root step, two radicand bits per cycle
    assign rem_sh = {rem_reg[wtse_pkg::REM_W-3:0], sq_reg[wtse_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // weighted sum, one product per cycle
    always_comb
    begin
        unique case (state_reg)
            wtse_pkg::S_MULP:
            begin
                mul_a = cfg.w_prox;
                mul_b = prox_reg;
            end
            wtse_pkg::S_MULC:
            begin
                mul_a = cfg.w_conf;
                mul_b = item_reg.conf;
            end
            default:
            begin
                mul_a = cfg.w_stab;
                mul_b = stab_reg;
            end
        endcase
        mul_p  = wtse_pkg::SACC_W'(mul_a * mul_b);
        s_full = sacc_reg[wtse_pkg::SACC_W-1:12];
        s_sat  = (s_full > (wtse_pkg::SACC_W-12)'(wtse_pkg::SCORE_MAX))
               ? wtse_pkg::SCORE_MAX : wtse_pkg::SCORE_W'(s_full);
    end

    // frame end choice
    always_comb
    begin
        lock_active = (cfg.lock_id != '0) & ~lock_void_reg;
        pick_lock   = lock_active & lock_seen_reg;
        pick_valid  = pick_lock | best_found_reg;
        pick_id     = pick_lock ? cfg.lock_id : best_id_reg;
        pick_u      = pick_lock ? lock_u_reg : best_u_reg;
        pick_v      = pick_lock ? lock_v_reg : best_v_reg;
        pick_dx     = $signed({1'b0, pick_u}) - $signed({1'b0, cfg.center_x});
        pick_dy     = $signed({1'b0, pick_v}) - $signed({1'b0, cfg.center_y});
        restart     = ~have_smooth_reg | (prev_id_reg != pick_id);
    end

    // EMA update for the lane in hand
    always_comb
    begin
        oma     = wtse_pkg::ALPHA_ONE - cfg.alpha;
        acc_sel = lane_reg ? acc_y_reg : acc_x_reg;
        raw_sel = lane_reg ? res_dy_reg : res_dx_reg;
        ema_sum = SUM_W'(p1_reg) + (SUM_W'(p2_reg) <<< 8) + SUM_W'(32768);
        ema_new = AW'(ema_sum >>> 16);
        sm_x    = (AW + 1)'(acc_x_reg) + (AW + 1)'(128);
        sm_y    = (AW + 1)'(acc_y_reg) + (AW + 1)'(128);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wtse_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_head.scored ? wtse_pkg::S_SQU : wtse_pkg::S_RANK;
                end
            end
            wtse_pkg::S_SQU:     state_next = wtse_pkg::S_SQV;
            wtse_pkg::S_SQV:     state_next = wtse_pkg::S_SQRT;
            wtse_pkg::S_SQRT:
            begin
                if (rcnt_reg == wtse_pkg::RCNT_W'(1))
                begin
                    state_next = wtse_pkg::S_DIVP_GO;
                end
            end
            wtse_pkg::S_DIVP_GO: state_next = wtse_pkg::S_DIVP_W;
            wtse_pkg::S_DIVP_W:
            begin
                if (!div_busy)
                begin
                    state_next = wtse_pkg::S_DIVS_GO;
                end
            end
            wtse_pkg::S_DIVS_GO: state_next = wtse_pkg::S_DIVS_W;
            wtse_pkg::S_DIVS_W:
            begin
                if (!div_busy)
                begin
                    state_next = wtse_pkg::S_MULP;
                end
            end
            wtse_pkg::S_MULP:    state_next = wtse_pkg::S_MULC;
            wtse_pkg::S_MULC:    state_next = wtse_pkg::S_MULS;
            wtse_pkg::S_MULS:    state_next = wtse_pkg::S_RANK;
            wtse_pkg::S_RANK:
            begin
                state_next = item_reg.last ? wtse_pkg::S_FRAME : wtse_pkg::S_IDLE;
            end
            wtse_pkg::S_FRAME:
            begin
                state_next = (pick_valid && !restart) ? wtse_pkg::S_EMA_A
                                                      : wtse_pkg::S_EMIT;
            end
            wtse_pkg::S_EMA_A:   state_next = wtse_pkg::S_EMA_B;
            wtse_pkg::S_EMA_B:   state_next = wtse_pkg::S_EMA_C;
            wtse_pkg::S_EMA_C:
            begin
                state_next = lane_reg ? wtse_pkg::S_EMIT : wtse_pkg::S_EMA_A;
            end
            wtse_pkg::S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = wtse_pkg::S_IDLE;
                end
            end
            default:             state_next = wtse_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop     = (state_reg == wtse_pkg::S_IDLE) & ~q_empty;
        div_start = (state_reg == wtse_pkg::S_DIVP_GO) | (state_reg == wtse_pkg::S_DIVS_GO);
        out_load  = (state_reg == wtse_pkg::S_EMIT) & (~out_valid_reg | pop);
        if (state_reg == wtse_pkg::S_DIVP_GO)
        begin
            div_num = wtse_pkg::NUM_PROX;
            div_den = wtse_pkg::DEN_W'(root_reg) + wtse_pkg::DEN_W'(16);
        end
        else
        begin
            div_num = wtse_pkg::NUM_STAB;
            div_den = wtse_pkg::DEN_W'(item_reg.eta) + wtse_pkg::DEN_W'(1024);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtse_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // scoring datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            wtse_pkg::S_IDLE:
            begin
                item_reg <= q_head;
            end
            wtse_pkg::S_SQU:
            begin
                sq_reg <= wtse_pkg::SQ_W'(sq_prod);
            end
            wtse_pkg::S_SQV:
            begin
                sq_reg   <= sq_reg + wtse_pkg::SQ_W'(sq_prod);
                rem_reg  <= '0;
                root_reg <= '0;
                rcnt_reg <= wtse_pkg::RCNT_W'(wtse_pkg::ROOT_W);
            end
            wtse_pkg::S_SQRT:
            begin
                sq_reg   <= sq_reg << 2;
                rcnt_reg <= rcnt_reg - 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[wtse_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[wtse_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            wtse_pkg::S_DIVP_W:
            begin
                prox_reg <= div_quo[wtse_pkg::PROX_W-1:0];
            end
            wtse_pkg::S_DIVS_W:
            begin
                stab_reg <= div_quo[wtse_pkg::PROX_W-1:0];
            end
            wtse_pkg::S_MULP:
            begin
                sacc_reg <= mul_p;
            end
            wtse_pkg::S_MULC, wtse_pkg::S_MULS:
            begin
                sacc_reg <= sacc_reg + mul_p;
            end
            wtse_pkg::S_EMA_A:
            begin
                p1_reg <= $signed({1'b0, oma}) * acc_sel;
            end
            wtse_pkg::S_EMA_B:
            begin
                p2_reg <= $signed({1'b0, cfg.alpha}) * raw_sel;
            end
            default:
            begin
            end
        endcase
    end

    // frame state, smoothing state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg  <= 1'b0;
            best_score_reg  <= '0;
            best_id_reg     <= '0;
            best_u_reg      <= '0;
            best_v_reg      <= '0;
            lock_seen_reg   <= 1'b0;
            lock_void_reg   <= 1'b0;
            lock_u_reg      <= '0;
            lock_v_reg      <= '0;
            have_smooth_reg <= 1'b0;
            prev_id_reg     <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            lane_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_id_reg      <= '0;
            res_dx_reg      <= '0;
            res_dy_reg      <= '0;
            res_score_reg   <= '0;
            out_valid_reg   <= 1'b0;
            target_valid    <= 1'b0;
            target_id       <= '0;
            raw_dx          <= '0;
            raw_dy          <= '0;
            smooth_dx       <= '0;
            smooth_dy       <= '0;
            score           <= '0;
        end
        else
        begin
            // lock register write reopens the lock
            if (cfg.lock_wr)
            begin
                lock_void_reg <= 1'b0;
                lock_seen_reg <= 1'b0;
            end

            // per item ranking
            if (state_reg == wtse_pkg::S_RANK)
            begin
                if (item_reg.present && item_reg.lock_match && lock_active && !lock_seen_reg)
                begin
                    lock_seen_reg <= 1'b1;
                    lock_u_reg    <= item_reg.u;
                    lock_v_reg    <= item_reg.v;
                end
                if (item_reg.scored && (!best_found_reg || s_sat > best_score_reg))
                begin
                    best_found_reg <= 1'b1;
                    best_score_reg <= s_sat;
                    best_id_reg    <= item_reg.id;
                    best_u_reg     <= item_reg.u;
                    best_v_reg     <= item_reg.v;
                end
            end

            // frame close
            if (state_reg == wtse_pkg::S_FRAME)
            begin
                if (lock_active && !lock_seen_reg)
                begin
                    lock_void_reg <= 1'b1;
                end
                best_found_reg <= 1'b0;
                best_score_reg <= '0;
                best_id_reg    <= '0;
                best_u_reg     <= '0;
                best_v_reg     <= '0;
                lock_seen_reg  <= 1'b0;
                lock_u_reg     <= '0;
                lock_v_reg     <= '0;
                lane_reg       <= 1'b0;
                res_valid_reg  <= pick_valid;
                if (pick_valid)
                begin
                    res_id_reg    <= pick_id;
                    res_dx_reg    <= pick_dx;
                    res_dy_reg    <= pick_dy;
                    res_score_reg <= pick_lock ? wtse_pkg::SCORE_MAX : best_score_reg;
                    prev_id_reg   <= pick_id;
                    if (restart)
                    begin
                        acc_x_reg       <= AW'(pick_dx) <<< 8;
                        acc_y_reg       <= AW'(pick_dy) <<< 8;
                        have_smooth_reg <= 1'b1;
                    end
                end
                else
                begin
                    have_smooth_reg <= 1'b0;
                    res_id_reg      <= '0;
                    res_dx_reg      <= '0;
                    res_dy_reg      <= '0;
                    res_score_reg   <= '0;
                end
            end

            // EMA write back, x lane then y lane
            if (state_reg == wtse_pkg::S_EMA_C)
            begin
                if (lane_reg)
                begin
                    acc_y_reg <= ema_new;
                end
                else
                begin
                    acc_x_reg <= ema_new;
                end
                lane_reg <= ~lane_reg;
            end

            // result register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                target_valid  <= res_valid_reg;
                target_id     <= res_id_reg;
                raw_dx        <= res_dx_reg;
                raw_dy        <= res_dy_reg;
                smooth_dx     <= res_valid_reg ? OW'(sm_x >>> 8) : '0;
                smooth_dy     <= res_valid_reg ? OW'(sm_y >>> 8) : '0;
                score         <= res_score_reg;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty = ~out_valid_reg;

endmodule

// ----- rtl/core/weighted_target_select_ema.sv -----
// weighted_target_select_ema: top level, configuration registers and the
// front queue feeding the scoring back end; depends on wtse_pkg, wtse_front, wtse_back
//
// channel   signals                          transfer when
// input     push, full, track fields         push & !full
// result    pop, empty, target fields        pop & !empty
// config    cfg_we, cfg_index, cfg_data      cfg_we
//
// a scored track passes through the queue pop, the squaring of u and v, one square
// root step per root bit (17), two serial divisions of 27 quotient bits each with a
// start state and a wait state, the three weighted products and the ranking state;
// other tracks go from the queue pop straight to the ranking state
// a closing item adds the frame choice, the EMA for both lanes when the smoothed
// target carries on, and the result load, which waits while a result is held
// the front queue holds two tracks, so input runs up to two tracks ahead
// reset is asynchronous and clears all frame and smoothing state
module weighted_target_select_ema (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  track_present,
    input  logic [wtse_pkg::ID_BITS-1:0]          track_id,
    input  logic                                  confirmed,
    input  logic                                  parent_label,
    input  logic [wtse_pkg::COORD_BITS-1:0]       pos_u,
    input  logic [wtse_pkg::COORD_BITS-1:0]       pos_v,
    input  logic signed [15:0]                    confidence,
    input  logic signed [15:0]                    eta_mean,
    input  logic                                  last_in_frame,
    input  logic                                  pop,
    output logic                                  empty,
    output logic                                  target_valid,
    output logic [wtse_pkg::ID_BITS-1:0]          target_id,
    output logic signed [wtse_pkg::OFF_W-1:0]     raw_dx,
    output logic signed [wtse_pkg::OFF_W-1:0]     raw_dy,
    output logic signed [wtse_pkg::OFF_W-1:0]     smooth_dx,
    output logic signed [wtse_pkg::OFF_W-1:0]     smooth_dy,
    output logic [wtse_pkg::SCORE_W-1:0]          score,
    input  logic                                  cfg_we,
    input  logic [wtse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wtse_pkg::CFG_W-1:0]            cfg_data
);

    wtse_pkg::cfg_t  cfg_reg;
    wtse_pkg::cfg_t  cfg_next;
    wtse_pkg::item_t q_head;
    logic            q_empty, q_pop;

    // register write decode
    always_comb
    begin
        cfg_next         = cfg_reg;
        cfg_next.lock_wr = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                wtse_pkg::REG_CENTER_X:
                    cfg_next.center_x = cfg_data[wtse_pkg::COORD_BITS-1:0];
                wtse_pkg::REG_CENTER_Y:
                    cfg_next.center_y = cfg_data[wtse_pkg::COORD_BITS-1:0];
                wtse_pkg::REG_W_PROX:
                    cfg_next.w_prox = cfg_data[wtse_pkg::WGT_W-1:0];
                wtse_pkg::REG_W_CONF:
                    cfg_next.w_conf = cfg_data[wtse_pkg::WGT_W-1:0];
                wtse_pkg::REG_W_STAB:
                    cfg_next.w_stab = cfg_data[wtse_pkg::WGT_W-1:0];
                wtse_pkg::REG_ALPHA:
                begin
                    if (cfg_data[wtse_pkg::ALPHA_W-1:0] > wtse_pkg::ALPHA_ONE)
                    begin
                        cfg_next.alpha = wtse_pkg::ALPHA_ONE;
                    end
                    else
                    begin
                        cfg_next.alpha = cfg_data[wtse_pkg::ALPHA_W-1:0];
                    end
                end
                wtse_pkg::REG_LOCK_ID:
                begin
                    cfg_next.lock_id = cfg_data[wtse_pkg::ID_BITS-1:0];
                    cfg_next.lock_wr = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.w_prox   <= wtse_pkg::WGT_ONE;
            cfg_reg.w_conf   <= wtse_pkg::WGT_ONE;
            cfg_reg.w_stab   <= wtse_pkg::WGT_ONE;
            cfg_reg.alpha    <= wtse_pkg::ALPHA_ONE >> 1;
            cfg_reg.lock_id  <= '0;
            cfg_reg.lock_wr  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // accept and classify
    wtse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .track_present (track_present),
        .track_id      (track_id),
        .confirmed     (confirmed),
        .parent_label  (parent_label),
        .pos_u         (pos_u),
        .pos_v         (pos_v),
        .confidence    (confidence),
        .eta_mean      (eta_mean),
        .last_in_frame (last_in_frame),
        .lock_id       (cfg_reg.lock_id),
        .q_pop         (q_pop),
        .q_empty       (q_empty),
        .q_head        (q_head)
    );

    // score, rank and smooth
    wtse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .target_valid (target_valid),
        .target_id    (target_id),
        .raw_dx       (raw_dx),
        .raw_dy       (raw_dy),
        .smooth_dx    (smooth_dx),
        .smooth_dy    (smooth_dy),
        .score        (score)
    );

endmodule

// ----- verif/tb_weighted_target_select_ema.sv -----
// tb_weighted_target_select_ema: self-checking bench for the weighted target selector
// with a built-in scoring and smoothing predictor; depends on wtse_pkg and the rtl top
`timescale 1ns / 100ps

module tb_weighted_target_select_ema;

    typedef struct {
        logic        present;
        logic [15:0] id;
        logic        confirmed;
        logic        parent;
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] conf;
        logic [15:0] eta;
        logic        last;
    } track_t;

    typedef struct {
        logic        valid;
        logic [15:0] id;
        logic [16:0] rdx;
        logic [16:0] rdy;
        logic [16:0] sdx;
        logic [16:0] sdy;
        logic [21:0] score;
    } aim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic track_present = 1'b0;
    logic [wtse_pkg::ID_BITS-1:0] track_id = '0;
    logic confirmed = 1'b0;
    logic parent_label = 1'b0;
    logic [wtse_pkg::COORD_BITS-1:0] pos_u = '0;
    logic [wtse_pkg::COORD_BITS-1:0] pos_v = '0;
    logic signed [15:0] confidence = '0;
    logic signed [15:0] eta_mean = '0;
    logic last_in_frame = 1'b0;
    logic pop = 1'b0;
    logic empty;
    logic target_valid;
    logic [wtse_pkg::ID_BITS-1:0] target_id;
    logic signed [wtse_pkg::OFF_W-1:0] raw_dx, raw_dy, smooth_dx, smooth_dy;
    logic [wtse_pkg::SCORE_W-1:0] score;
    logic cfg_we = 1'b0;
    logic [wtse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wtse_pkg::CFG_W-1:0] cfg_data = '0;

    weighted_target_select_ema i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .track_present(track_present), .track_id(track_id), .confirmed(confirmed),
        .parent_label(parent_label), .pos_u(pos_u), .pos_v(pos_v),
        .confidence(confidence), .eta_mean(eta_mean), .last_in_frame(last_in_frame),
        .pop(pop), .empty(empty), .target_valid(target_valid), .target_id(target_id),
        .raw_dx(raw_dx), .raw_dy(raw_dy), .smooth_dx(smooth_dx), .smooth_dy(smooth_dy),
        .score(score), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    track_t track_q[$];
    aim_t   aim_q[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     stall_req = 0;
    int     stall_done = 0;
    int     stall_left = 0;

    // predictor copy of registers and frame state
    longint cx, cy, wp, wc, ws, alpha;
    logic [15:0] lock_id;
    longint best_sc, acc_x, acc_y;
    logic [15:0] best_id, best_u, best_v, lk_u, lk_v, prev_id;
    bit best_found, lk_seen, lk_void, have_smooth;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint root_floor(longint x);
        longint r = 0;
        longint b = longint'(1) << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint track_score(track_t t);
        longint du, dv, d, prox, cf, e, stab, s;
        du = longint'(t.u) - cx;
        dv = longint'(t.v) - cy;
        d = root_floor(du * du + dv * dv);
        prox = (longint'(1) << 20) / (16 + d);
        cf = t.conf[15] ? 0 : longint'(t.conf) * 2;
        e = t.eta[15] ? 0 : longint'(t.eta);
        stab = (longint'(1) << 26) / (1024 + e);
        s = (wp * prox + wc * cf + ws * stab) >> 12;
        return (s > 4194303) ? 4194303 : s;
    endfunction

    function automatic longint smooth_step(longint acc, longint raw);
        return ((65536 - alpha) * acc + alpha * raw * 256 + 32768) >>> 16;
    endfunction

    // frame accumulation and result prediction per accepted transfer
    task automatic predict_aim(track_t t);
        bit lock_on, ok;
        logic [15:0] cid, cu, cv;
        longint sc, s, rdx, rdy;
        aim_t r;
        lock_on = (lock_id != 0) && !lk_void;
        ok = 0;
        if (t.present)
        begin
            if (lock_on && !lk_seen && t.id == lock_id)
            begin
                lk_seen = 1; lk_u = t.u; lk_v = t.v;
            end
            if (t.confirmed && t.parent)
            begin
                s = track_score(t);
                if (!best_found || s > best_sc)
                begin
                    best_found = 1; best_sc = s; best_id = t.id;
                    best_u = t.u; best_v = t.v;
                end
            end
        end
        if (!t.last) return;
        if (lock_on && lk_seen)
        begin
            ok = 1; cid = lock_id; cu = lk_u; cv = lk_v; sc = 4194303;
        end
        else
        begin
            if (lock_on) lk_void = 1;
            if (best_found)
            begin
                ok = 1; cid = best_id; cu = best_u; cv = best_v; sc = best_sc;
            end
        end
        best_found = 0; best_sc = 0; lk_seen = 0;
        r = '{default: '0};
        if (!ok)
            have_smooth = 0;
        else
        begin
            rdx = longint'(cu) - cx;
            rdy = longint'(cv) - cy;
            if (!have_smooth || prev_id != cid)
            begin
                acc_x = rdx * 256; acc_y = rdy * 256; have_smooth = 1;
            end
            else
            begin
                acc_x = smooth_step(acc_x, rdx);
                acc_y = smooth_step(acc_y, rdy);
            end
            prev_id = cid;
            r.valid = 1; r.id = cid; r.rdx = rdx[16:0]; r.rdy = rdy[16:0];
            r.sdx = ((acc_x + 128) >>> 8) & 17'h1FFFF;
            r.sdy = ((acc_y + 128) >>> 8) & 17'h1FFFF;
            r.score = sc[21:0];
        end
        aim_q.push_back(r);
    endtask

    // driver: offers the head of the pending queue
    always @(posedge clk)
    begin
        track_t t;
        bit go;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                t = track_q.pop_front();
                predict_aim(t);
            end
            go = (track_q.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
            push <= go;
            if (go)
            begin
                t = track_q[0];
                track_present <= t.present; track_id <= t.id;
                confirmed <= t.confirmed; parent_label <= t.parent;
                pos_u <= t.u; pos_v <= t.v;
                confidence <= t.conf; eta_mean <= t.eta;
                last_in_frame <= t.last;
            end
        end
    end

    // monitor: random pop, long hold-off on request, field compare
    always @(posedge clk)
    begin
        aim_t e;
        bit take;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (aim_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with none expected, id %0d", $time,
                             target_id);
                end
                else
                begin
                    e = aim_q.pop_front();
                    if (target_valid !== e.valid || target_id !== e.id
                        || raw_dx !== e.rdx || raw_dy !== e.rdy
                        || smooth_dx !== e.sdx || smooth_dy !== e.sdy
                        || score !== e.score)
                    begin
                        errors++;
                        $display("%0t: expected v%0d id %0d raw %0d,%0d smooth %0d,%0d sc %0d",
                                 $time, e.valid, e.id, $signed(e.rdx), $signed(e.rdy),
                                 $signed(e.sdx), $signed(e.sdy), e.score);
                        $display("%0t: actual   v%0d id %0d raw %0d,%0d smooth %0d,%0d sc %0d",
                                 $time, target_valid, target_id, raw_dx, raw_dy,
                                 smooth_dx, smooth_dy, score);
                    end
                end
            end
            if (stall_req != stall_done)
            begin
                stall_done = stall_req;
                stall_left = 4000;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                take = 0;
            end
            else
                take = $urandom_range(0, 99) >= recv_idle_pct;
            pop <= take;
        end
    end

    function automatic track_t make_track(logic [15:0] id, bit ok, logic [15:0] u,
                                          logic [15:0] v, logic [15:0] cf,
                                          logic [15:0] eta, bit last);
        track_t t;
        t.present = 1; t.id = id; t.confirmed = ok; t.parent = ok;
        t.u = u; t.v = v; t.conf = cf; t.eta = eta; t.last = last;
        return t;
    endfunction

    function automatic track_t rand_track(bit last);
        track_t t;
        t.present = ($urandom_range(0, 19) != 0);
        t.id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 6));
        t.confirmed = ($urandom_range(0, 3) != 0);
        t.parent = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1))
        begin
            t.u = 16'(cx + $urandom_range(0, 1023) - 512);
            t.v = 16'(cy + $urandom_range(0, 1023) - 512);
        end
        else
        begin
            t.u = 16'($urandom); t.v = 16'($urandom);
        end
        t.conf = 16'($urandom);
        t.eta = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 2047)) : 16'($urandom);
        t.last = last;
        return t;
    endfunction

    // wait until every queued track is in and every result is out
    task automatic drain;
        while (track_q.size() != 0 || push || aim_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic cfg_write(logic [wtse_pkg::CFG_IDX_W-1:0] idx, longint val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[wtse_pkg::CFG_W-1:0];
        case (idx)
            wtse_pkg::REG_CENTER_X: cx = val & 16'hFFFF;
            wtse_pkg::REG_CENTER_Y: cy = val & 16'hFFFF;
            wtse_pkg::REG_W_PROX:   wp = val & 16'hFFFF;
            wtse_pkg::REG_W_CONF:   wc = val & 16'hFFFF;
            wtse_pkg::REG_W_STAB:   ws = val & 16'hFFFF;
            wtse_pkg::REG_ALPHA:
                alpha = ((val & 17'h1FFFF) > 65536) ? 65536 : (val & 17'h1FFFF);
            wtse_pkg::REG_LOCK_ID:
            begin
                lock_id = val[15:0]; lk_void = 0; lk_seen = 0;
            end
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic longint pick16();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin
        track_t z;
        int queued;
        int n;
        cx = 0; cy = 0; wp = 4096; wc = 4096; ws = 4096; alpha = 32768; lock_id = 0;
        best_found = 0; best_sc = 0; lk_seen = 0; lk_void = 0; have_smooth = 0;
        acc_x = 0; acc_y = 0; prev_id = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: field extremes, empty marker, no winner, ties, smoothing run
        z = make_track(0, 0, 0, 0, 0, 0, 1);
        z.present = 0;
        track_q.push_back(make_track(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1));
        track_q.push_back(make_track(1, 1, 0, 0, 16'h8000, 16'h7FFF, 1));
        track_q.push_back(z);
        track_q.push_back(make_track(2, 0, 100, 100, 16'h4000, 0, 1));
        z.last = 0; track_q.push_back(z);
        track_q.push_back(make_track(3, 1, 50, 60, 16'h1000, 10, 0));
        track_q.push_back(make_track(4, 1, 50, 60, 16'h1000, 10, 1));
        track_q.push_back(make_track(3, 1, 80, 20, 16'h1000, 10, 1));
        track_q.push_back(make_track(3, 1, 90, 25, 16'h1000, 10, 1));
        track_q.push_back(make_track(3, 1, 95, 27, 16'h1000, 10, 1));
        drain();
        // lock: duplicate id, unconfirmed winner, absent id voids it
        cfg_write(wtse_pkg::REG_ALPHA, 131071);
        cfg_write(wtse_pkg::REG_LOCK_ID, 5);
        track_q.push_back(make_track(7, 1, 10, 10, 16'h7FFF, 0, 0));
        track_q.push_back(make_track(5, 0, 300, 400, 0, 0, 0));
        track_q.push_back(make_track(5, 0, 500, 600, 0, 0, 1));
        track_q.push_back(make_track(7, 1, 10, 10, 16'h7FFF, 0, 1));
        track_q.push_back(make_track(5, 1, 20, 30, 0, 0, 1));
        drain();
        cfg_write(wtse_pkg::REG_LOCK_ID, 5);
        track_q.push_back(make_track(5, 0, 20, 30, 0, 0, 1));
        drain();

        // random phases, each with its own register setting
        queued = 0;
        for (int ph = 0; ph < 9; ph++)
        begin
            send_idle_pct = (ph < 3) ? 20 : (ph < 6) ? 75 : 0;
            recv_idle_pct = (ph < 3) ? 75 : (ph < 6) ? 20 : 0;
            cfg_write(wtse_pkg::REG_CENTER_X, (ph == 1) ? 65535 : pick16());
            cfg_write(wtse_pkg::REG_CENTER_Y, (ph == 1) ? 0 : pick16());
            cfg_write(wtse_pkg::REG_W_PROX, (ph == 2) ? 0 : pick16());
            cfg_write(wtse_pkg::REG_W_CONF, (ph == 2) ? 65535 : pick16());
            cfg_write(wtse_pkg::REG_W_STAB, pick16());
            cfg_write(wtse_pkg::REG_ALPHA,
                      (ph == 3) ? 0 : (ph == 4) ? 65536 : $urandom_range(0, 131071));
            case ($urandom_range(0, 2))
                0: cfg_write(wtse_pkg::REG_LOCK_ID, 0);
                1: cfg_write(wtse_pkg::REG_LOCK_ID, $urandom_range(1, 6));
                default: cfg_write(wtse_pkg::REG_LOCK_ID, pick16());
            endcase
            if (ph == 1) stall_req++;
            while (queued < (ph + 1) * 190)
            begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) track_q.push_back(rand_track(k == n - 1));
                queued += n;
                while (track_q.size() > 8) @(posedge clk);
            end
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
